// ----- hdl/owbm_pkg.sv -----
// Shared types and constants for the single-wire bus master.
package owbm_pkg;

   localparam int TICK_W = 10;
   localparam int NUM_REGS = 8;
   localparam int REG_IDX_W = 3;

   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_RESET = 2'd1;
   localparam logic [1:0] CMD_WRITE = 2'd2;
   localparam logic [1:0] CMD_READ  = 2'd3;

   localparam logic [3:0] PH_IDLE     = 4'd0;
   localparam logic [3:0] PH_RST_LOW  = 4'd1;
   localparam logic [3:0] PH_RST_WAIT = 4'd2;
   localparam logic [3:0] PH_RST_REC  = 4'd3;
   localparam logic [3:0] PH_WR_LOW   = 4'd4;
   localparam logic [3:0] PH_WR_HOLD  = 4'd5;
   localparam logic [3:0] PH_RD_LOW   = 4'd6;
   localparam logic [3:0] PH_RD_WAIT  = 4'd7;
   localparam logic [3:0] PH_RD_REC   = 4'd8;

   localparam logic [2:0] REG_RESET_LOW    = 3'd0;
   localparam logic [2:0] REG_PRESENCE     = 3'd1;
   localparam logic [2:0] REG_RESET_REC    = 3'd2;
   localparam logic [2:0] REG_WRITE_LOW    = 3'd3;
   localparam logic [2:0] REG_WRITE_HOLD   = 3'd4;
   localparam logic [2:0] REG_READ_LOW     = 3'd5;
   localparam logic [2:0] REG_READ_SAMPLE  = 3'd6;
   localparam logic [2:0] REG_READ_REC     = 3'd7;

   localparam logic [9:0] RST_RESET_LOW   = 10'd500;
   localparam logic [9:0] RST_PRESENCE    = 10'd70;
   localparam logic [9:0] RST_RESET_REC   = 10'd500;
   localparam logic [9:0] RST_WRITE_LOW   = 10'd10;
   localparam logic [9:0] RST_WRITE_HOLD  = 10'd50;
   localparam logic [9:0] RST_READ_LOW    = 10'd5;
   localparam logic [9:0] RST_READ_SAMPLE = 10'd5;
   localparam logic [9:0] RST_READ_REC    = 10'd50;

   localparam logic [7:0] BIT_ONE = 8'h01;

   typedef logic [NUM_REGS-1:0][TICK_W-1:0] tick_regs_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] data_byte;
      logic       line_in;
   } req_type;

   typedef struct packed {
      logic       pull_low;
      logic       busy_res;
      logic       done_res;
      logic       no_device;
      logic [7:0] read_data;
   } rsp_type;

endpackage

// ----- hdl/one_wire_bus_master_top.sv -----
// Top level of the single-wire bus master: request and response registers around the sequencer.
// A request is held in the request register, then its result in the response register.
// Throughput: one request per cycle unless stalled; each request is one sequencer tick.
// req_stall rises only while the request register is full and the response is stalled.
// Reset (synchronous, active high) clears both handshake registers, idles the sequencer,
// sets no_device to 1 and loads the default timing registers.
module one_wire_bus_master_top
   import owbm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [REG_IDX_W-1:0] csr_addr,
   input  logic [TICK_W-1:0]    csr_wdata
);

   logic          in_valid_ff;
   req_type       in_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff;
   logic          advance;
   tick_regs_type regs;
   rsp_type       step_result;

   assign advance   = in_valid_ff && !(rsp_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && rsp_valid_ff && rsp_stall;

   owbm_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .regs      (regs)
   );

   owbm_core u_core (
      .clock  (clock),
      .reset  (reset),
      .en     (advance),
      .item   (in_ff),
      .regs   (regs),
      .result (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- hdl/owbm_regs.sv -----
// Timing configuration registers of the single-wire bus master.
module owbm_regs
   import owbm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [REG_IDX_W-1:0] csr_addr,
   input  logic [TICK_W-1:0]    csr_wdata,
   output tick_regs_type        regs
);

   tick_regs_type regs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff[REG_RESET_LOW]   <= RST_RESET_LOW;
         regs_ff[REG_PRESENCE]    <= RST_PRESENCE;
         regs_ff[REG_RESET_REC]   <= RST_RESET_REC;
         regs_ff[REG_WRITE_LOW]   <= RST_WRITE_LOW;
         regs_ff[REG_WRITE_HOLD]  <= RST_WRITE_HOLD;
         regs_ff[REG_READ_LOW]    <= RST_READ_LOW;
         regs_ff[REG_READ_SAMPLE] <= RST_READ_SAMPLE;
         regs_ff[REG_READ_REC]    <= RST_READ_REC;
      end else if (csr_we) begin
         regs_ff[csr_addr] <= csr_wdata;
      end
   end

   assign regs = regs_ff;

endmodule

// ----- hdl/owbm_core.sv -----
// Bus sequencer state and per-tick next-state logic.
module owbm_core
   import owbm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  req_type       item,
   input  tick_regs_type regs,
   output rsp_type       result
);

   logic [3:0]        phase_ff, phase_in;
   logic [TICK_W-1:0] tick_count_ff, tick_count_in;
   logic [2:0]        bit_index_ff, bit_index_in;
   logic [7:0]        send_shift_ff, send_shift_in;
   logic [7:0]        recv_shift_ff, recv_shift_in;
   logic              presence_ff, presence_in;

   logic [TICK_W-1:0] cur_len;
   logic [2:0]        len_idx;
   logic              pull;
   logic              done;

   assign len_idx = 3'(phase_ff - 4'd1);
   assign cur_len = regs[len_idx];

   always_comb begin
      phase_in      = phase_ff;
      tick_count_in = tick_count_ff;
      bit_index_in  = bit_index_ff;
      send_shift_in = send_shift_ff;
      recv_shift_in = recv_shift_ff;
      presence_in   = presence_ff;
      pull          = 1'b0;
      done          = 1'b0;

      if (phase_ff == PH_IDLE && item.cmd != CMD_TICK) begin
         tick_count_in = '0;
         bit_index_in  = '0;
         case (item.cmd)
            CMD_RESET: begin
               phase_in = PH_RST_LOW;
            end
            CMD_WRITE: begin
               send_shift_in = item.data_byte;
               phase_in      = PH_WR_LOW;
            end
            default: begin
               recv_shift_in = '0;
               phase_in      = PH_RD_LOW;
            end
         endcase
      end

      if (phase_in != PH_IDLE) begin
         if (phase_in inside {PH_RST_LOW, PH_WR_LOW, PH_RD_LOW}) begin
            pull = 1'b1;
         end else if (phase_in == PH_WR_HOLD) begin
            pull = ~send_shift_in[bit_index_in];
         end
         tick_count_in = tick_count_in + 1'b1;
         if (tick_count_in >= regs[3'(phase_in - 4'd1)]) begin
            tick_count_in = '0;
            case (phase_in)
               PH_RST_LOW:  phase_in = PH_RST_WAIT;
               PH_RST_WAIT: begin
                  presence_in = item.line_in;
                  phase_in    = PH_RST_REC;
               end
               PH_RST_REC: begin
                  phase_in = PH_IDLE;
                  done     = 1'b1;
               end
               PH_WR_LOW:   phase_in = PH_WR_HOLD;
               PH_RD_LOW:   phase_in = PH_RD_WAIT;
               PH_RD_WAIT: begin
                  if (item.line_in) begin
                     recv_shift_in = recv_shift_in | (BIT_ONE << bit_index_in);
                  end
                  phase_in = PH_RD_REC;
               end
               PH_WR_HOLD, PH_RD_REC: begin
                  if (bit_index_in == 3'd7) begin
                     bit_index_in = '0;
                     phase_in     = PH_IDLE;
                     done         = 1'b1;
                  end else begin
                     bit_index_in = bit_index_in + 3'd1;
                     phase_in     = (phase_in == PH_WR_HOLD) ? PH_WR_LOW : PH_RD_LOW;
                  end
               end
               default:     phase_in = PH_IDLE;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         tick_count_ff <= '0;
         bit_index_ff  <= '0;
         send_shift_ff <= '0;
         recv_shift_ff <= '0;
         presence_ff   <= 1'b1;
      end else if (en) begin
         phase_ff      <= phase_in;
         tick_count_ff <= tick_count_in;
         bit_index_ff  <= bit_index_in;
         send_shift_ff <= send_shift_in;
         recv_shift_ff <= recv_shift_in;
         presence_ff   <= presence_in;
      end
   end

   assign result.pull_low  = pull;
   assign result.busy_res  = (phase_in != PH_IDLE);
   assign result.done_res  = done;
   assign result.no_device = presence_in;
   assign result.read_data = recv_shift_in;

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> (bit_index_ff == '0 && tick_count_ff == '0))
      else $error("idle with live slot counters");

   a_tick_bound: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_IDLE && cur_len != '0) |-> tick_count_ff < cur_len)
      else $error("tick count past phase length");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (en && done) |=> phase_ff == PH_IDLE)
      else $error("done without returning to idle");

endmodule

// ----- tb/sv/one_wire_bus_master_top_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the single-wire bus master: directed and random bus operations.
module one_wire_bus_master_top_tb;
   import owbm_pkg::*;

   typedef enum int {LINE_LOW, LINE_HIGH, LINE_RAND} line_mode_type;

   logic          clock = 1'b0;
   logic          reset;
   logic          req_valid;
   logic          req_stall;
   req_type       req_data;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   rsp_type       rsp_data;
   logic          csr_we;
   logic [REG_IDX_W-1:0] csr_addr;
   logic [TICK_W-1:0]    csr_wdata;

   one_wire_bus_master_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // bus sequencer mirror
   tick_regs_type slot_ticks;
   logic [3:0]    bus_phase;
   logic [9:0]    phase_ticks;
   logic [2:0]    bit_pos;
   logic [7:0]    tx_byte;
   logic [7:0]    rx_byte;
   logic          no_answer;
   logic [1:0]    active_cmd;

   rsp_type expected_rsp_q[$];
   rsp_type want;

   int n_errors = 0;
   int n_checked = 0;
   int n_reqs = 0;
   int n_work = 0;
   int n_settings = 0;
   int n_in_stall = 0;
   int op_count[4] = '{0, 0, 0, 0};
   int burst_left = 0;
   bit gaps_on = 1'b0;
   int holdoff_request = 0;
   int hold_cnt = 0;
   int cyc = 0;

   function automatic rsp_type bus_step(req_type r);
      rsp_type o;
      logic    drive_low;
      logic    fin;
      drive_low = 1'b0;
      fin = 1'b0;
      if (bus_phase == PH_IDLE && r.cmd != CMD_TICK) begin
         active_cmd = r.cmd;
         phase_ticks = '0;
         bit_pos = '0;
         case (r.cmd)
            CMD_RESET: bus_phase = PH_RST_LOW;
            CMD_WRITE: begin
               tx_byte = r.data_byte;
               bus_phase = PH_WR_LOW;
            end
            default: begin
               rx_byte = '0;
               bus_phase = PH_RD_LOW;
            end
         endcase
      end
      if (bus_phase != PH_IDLE) begin
         if (bus_phase inside {PH_RST_LOW, PH_WR_LOW, PH_RD_LOW})
            drive_low = 1'b1;
         else if (bus_phase == PH_WR_HOLD)
            drive_low = ~tx_byte[bit_pos];
         phase_ticks = phase_ticks + 10'd1;
         if (phase_ticks >= slot_ticks[3'(bus_phase - PH_RST_LOW)]) begin
            phase_ticks = '0;
            case (bus_phase)
               PH_RST_LOW:  bus_phase = PH_RST_WAIT;
               PH_RST_WAIT: begin
                  no_answer = r.line_in;
                  bus_phase = PH_RST_REC;
               end
               PH_RST_REC: begin
                  bus_phase = PH_IDLE;
                  fin = 1'b1;
               end
               PH_WR_LOW:   bus_phase = PH_WR_HOLD;
               PH_RD_LOW:   bus_phase = PH_RD_WAIT;
               PH_RD_WAIT: begin
                  if (r.line_in)
                     rx_byte[bit_pos] = 1'b1;
                  bus_phase = PH_RD_REC;
               end
               PH_WR_HOLD, PH_RD_REC: begin
                  if (bit_pos == 3'd7) begin
                     bit_pos = '0;
                     bus_phase = PH_IDLE;
                     fin = 1'b1;
                  end else begin
                     bit_pos = bit_pos + 3'd1;
                     bus_phase = (bus_phase == PH_WR_HOLD) ? PH_WR_LOW : PH_RD_LOW;
                  end
               end
               default: bus_phase = PH_IDLE;
            endcase
         end
      end
      o.pull_low  = drive_low;
      o.busy_res  = (bus_phase != PH_IDLE);
      o.done_res  = fin;
      o.no_device = no_answer;
      o.read_data = rx_byte;
      return o;
   endfunction

   function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
      if (act_v !== exp_v) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
         n_errors++;
      end
   endfunction

   // response checker and receiver stall pattern
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (expected_rsp_q.size() == 0) begin
            $error("response with no request outstanding");
            n_errors++;
         end else begin
            want = expected_rsp_q.pop_front();
            check_field("pull_low", 8'(want.pull_low), 8'(rsp_data.pull_low));
            check_field("busy_res", 8'(want.busy_res), 8'(rsp_data.busy_res));
            check_field("done_res", 8'(want.done_res), 8'(rsp_data.done_res));
            check_field("no_device", 8'(want.no_device), 8'(rsp_data.no_device));
            check_field("read_data", want.read_data, rsp_data.read_data);
            n_checked++;
         end
      end
      if (req_stall === 1'b1)
         n_in_stall++;
      cyc++;
      if (holdoff_request > 0) begin
         hold_cnt = holdoff_request;
         holdoff_request = 0;
      end
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_stall <= 1'b1;
      end else if (cyc % 640 < 160) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 3) == 0);
      end
   end

   task automatic send_req(input req_type r);
      if (gaps_on && burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      if (burst_left > 0)
         burst_left--;
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (bus_phase != PH_IDLE || r.cmd != CMD_TICK)
         n_work++;
      n_reqs++;
      expected_rsp_q.push_back(bus_step(r));
   endtask

   function automatic logic line_level(line_mode_type mode);
      if (mode == LINE_RAND)
         return 1'($urandom_range(0, 1));
      return (mode == LINE_HIGH);
   endfunction

   // one command, then ticks (with optional ignored commands) until the bus is idle
   task automatic run_op(input logic [1:0] cmd, input logic [7:0] data, input line_mode_type mode,
                         input int noise_pct);
      req_type r;
      r.cmd = cmd;
      r.data_byte = data;
      r.line_in = line_level(mode);
      if (bus_phase == PH_IDLE)
         op_count[cmd]++;
      send_req(r);
      while (bus_phase != PH_IDLE) begin
         if ($urandom_range(1, 100) <= noise_pct)
            r.cmd = 2'($urandom_range(CMD_RESET, CMD_READ));
         else
            r.cmd = CMD_TICK;
         r.data_byte = 8'($urandom);
         r.line_in = line_level(mode);
         send_req(r);
      end
   endtask

   task automatic settle_bus();
      req_type r;
      r = '0;
      while (bus_phase != PH_IDLE) send_req(r);
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // writes only the registers picked by sel
   task automatic load_regs(input tick_regs_type v, input logic [NUM_REGS-1:0] sel);
      settle_bus();
      for (int i = 0; i < NUM_REGS; i++) begin
         if (sel[i]) begin
            csr_we <= 1'b1;
            csr_addr <= REG_IDX_W'(i);
            csr_wdata <= v[i];
            slot_ticks[i] = v[i];
            @(posedge clock);
         end
      end
      csr_we <= 1'b0;
      n_settings++;
   endtask

   task automatic write_timing(input tick_regs_type v);
      load_regs(v, '1);
   endtask

   function automatic tick_regs_type make_timing(int lo, int hi);
      tick_regs_type v;
      for (int i = 0; i < NUM_REGS; i++)
         v[i] = TICK_W'($urandom_range(lo, hi));
      return v;
   endfunction

   // write-low, read-low and read-sample keep their reset values
   task automatic test_power_on_defaults();
      req_type             r;
      logic [NUM_REGS-1:0] sel;
      gaps_on = 1'b0;
      r = '0;
      send_req(r);
      r.data_byte = 8'hFF;
      r.line_in = 1'b1;
      send_req(r);
      sel = '1;
      sel[REG_WRITE_LOW] = 1'b0;
      sel[REG_READ_LOW] = 1'b0;
      sel[REG_READ_SAMPLE] = 1'b0;
      load_regs(make_timing(1, 1), sel);
      run_op(CMD_RESET, 8'h3C, LINE_LOW, 0);
      gaps_on = 1'b1;
      run_op(CMD_WRITE, 8'hA5, LINE_RAND, 0);
      run_op(CMD_READ, 8'hFF, LINE_RAND, 0);
   endtask

   task automatic test_shortest_slots();
      write_timing(make_timing(1, 1));
      gaps_on = 1'b0;
      run_op(CMD_WRITE, 8'h00, LINE_HIGH, 0);
      run_op(CMD_WRITE, 8'hFF, LINE_LOW, 0);
      gaps_on = 1'b1;
      run_op(CMD_READ, 8'h00, LINE_HIGH, 0);
      run_op(CMD_READ, 8'hFF, LINE_LOW, 0);
      run_op(CMD_RESET, 8'h00, LINE_HIGH, 0);
      run_op(CMD_RESET, 8'hFF, LINE_LOW, 0);
   endtask

   // a zero register value behaves as one tick
   task automatic test_zero_timing();
      write_timing(make_timing(0, 0));
      run_op(CMD_WRITE, 8'h5A, LINE_RAND, 0);
      run_op(CMD_READ, 8'h00, LINE_RAND, 0);
      run_op(CMD_RESET, 8'h00, LINE_RAND, 0);
   endtask

   task automatic test_busy_commands();
      write_timing(make_timing(1, 2));
      run_op(CMD_RESET, 8'h81, LINE_RAND, 100);
      run_op(CMD_WRITE, 8'h66, LINE_RAND, 100);
      run_op(CMD_READ, 8'h99, LINE_RAND, 100);
   endtask

   task automatic test_backpressure();
      write_timing(make_timing(1, 3));
      gaps_on = 1'b0;
      holdoff_request = 300;
      run_op(CMD_WRITE, 8'($urandom), LINE_RAND, 0);
      run_op(CMD_READ, 8'h00, LINE_RAND, 0);
      run_op(CMD_RESET, 8'h00, LINE_RAND, 0);
   endtask

   task automatic test_random_traffic();
      req_type r;
      int      start;
      int      lo[4] = '{1, 1, 1, 2};
      int      hi[4] = '{2, 4, 6, 6};
      for (int s = 0; s < 4; s++) begin
         write_timing(make_timing(lo[s], hi[s]));
         start = n_work;
         while (n_work - start < 60) begin
            gaps_on = ($urandom_range(0, 2) != 0);
            if ($urandom_range(0, 4) != 0) begin
               run_op(2'($urandom_range(CMD_RESET, CMD_READ)), 8'($urandom), LINE_RAND, 8);
            end else begin
               repeat ($urandom_range(1, 5)) begin
                  r.cmd = 2'($urandom_range(CMD_TICK, CMD_READ));
                  r.data_byte = 8'($urandom);
                  r.line_in = 1'($urandom_range(0, 1));
                  send_req(r);
               end
            end
         end
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_we <= 1'b0;
      csr_addr <= '0;
      csr_wdata <= '0;
      slot_ticks[REG_RESET_LOW] = RST_RESET_LOW;
      slot_ticks[REG_PRESENCE] = RST_PRESENCE;
      slot_ticks[REG_RESET_REC] = RST_RESET_REC;
      slot_ticks[REG_WRITE_LOW] = RST_WRITE_LOW;
      slot_ticks[REG_WRITE_HOLD] = RST_WRITE_HOLD;
      slot_ticks[REG_READ_LOW] = RST_READ_LOW;
      slot_ticks[REG_READ_SAMPLE] = RST_READ_SAMPLE;
      slot_ticks[REG_READ_REC] = RST_READ_REC;
      bus_phase = PH_IDLE;
      phase_ticks = '0;
      bit_pos = '0;
      tx_byte = '0;
      rx_byte = '0;
      no_answer = 1'b1;
      active_cmd = CMD_TICK;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_power_on_defaults();
      test_shortest_slots();
      test_zero_timing();
      test_busy_commands();
      test_backpressure();
      test_random_traffic();

      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("Ran %0d requests: %0d bus resets, %0d byte writes, %0d byte reads",
               n_reqs, op_count[CMD_RESET], op_count[CMD_WRITE], op_count[CMD_READ]);
      $display("Checked %0d responses over %0d timing settings, input stalled %0d cycles",
               n_checked, n_settings, n_in_stall);
      if (n_errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
